// ----- src/sodm_pkg.sv -----
// Shared types and constants for the sub-octave divider mixer.
// No dependencies; every other file refers to it by scoped names.
package sodm_pkg;

	localparam int unsigned GAIN_W  = 9;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned DEN_W   = 11;

	localparam logic [GAIN_W-1:0] Q8_ONE     = 9'd256;
	localparam logic [MODE_W-1:0] MODE_MAX   = 3'd5;
	localparam logic [CNT_W-1:0]  K_BASE     = 4'd2;

	// Configuration register indexes.
	typedef enum logic [MODE_W-1:0] {
		REG_DRY_GAIN  = 3'd0,
		REG_XOVER_LVL = 3'd1,
		REG_SUB1_GAIN = 3'd2,
		REG_SUB2_GAIN = 3'd3,
		REG_DIV_MODE  = 3'd4
	} cfg_reg_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DIV,
		ST_OUT
	} seq_state_t;

	// Status of the serial divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- src/sodm_xdet.sv -----
// Threshold crossing detectors and the two divided square waves.
// Uses sodm_pkg for widths and the divide-mode constants.
module sodm_xdet #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic signed [sodm_pkg::LEVEL_W-1:0]   level,
	input  logic        [sodm_pkg::MODE_W-1:0]    mode,
	output logic                                  sq_a,
	output logic                                  sq_b
);

	localparam int unsigned XW = (SAMPLE_BITS > sodm_pkg::LEVEL_W) ? SAMPLE_BITS
	                                                               : sodm_pkg::LEVEL_W;

	logic signed [XW-1:0]               x_ext;
	logic signed [XW-1:0]               lvl_ext;
	logic                               now_above;
	logic [sodm_pkg::MODE_W-1:0]        mode_c;
	logic [sodm_pkg::CNT_W-1:0]         k_a;
	logic [sodm_pkg::CNT_W-1:0]         k_b;
	logic [sodm_pkg::CNT_W-1:0]         cnt_a_inc;
	logic [sodm_pkg::CNT_W-1:0]         cnt_b_inc;
	logic                               tog_a;
	logic                               tog_b;

	logic                               above_a_q;
	logic                               above_b_q;
	logic                               sq_a_q;
	logic                               sq_b_q;
	logic [sodm_pkg::CNT_W-1:0]         cnt_a_q;
	logic [sodm_pkg::CNT_W-1:0]         cnt_b_q;

	always_comb begin
		x_ext     = XW'(sample);
		lvl_ext   = XW'(level);
		now_above = x_ext > lvl_ext;
		mode_c    = (mode > sodm_pkg::MODE_MAX) ? sodm_pkg::MODE_MAX : mode;
		k_a       = sodm_pkg::CNT_W'(mode_c) + sodm_pkg::K_BASE;
		k_b       = {k_a[sodm_pkg::CNT_W-2:0], 1'b0};
		cnt_a_inc = (now_above != above_a_q) ? cnt_a_q + 4'd1 : cnt_a_q;
		cnt_b_inc = (now_above != above_b_q) ? cnt_b_q + 4'd1 : cnt_b_q;
		// At-least compare, so a smaller K written later still lets a square toggle.
		tog_a     = cnt_a_inc >= k_a;
		tog_b     = cnt_b_inc >= k_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_a_q <= 1'b0;
			above_b_q <= 1'b0;
			sq_a_q    <= 1'b0;
			sq_b_q    <= 1'b0;
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
		end else if (accept) begin
			above_a_q <= now_above;
			above_b_q <= now_above;
			sq_a_q    <= sq_a_q ^ tog_a;
			sq_b_q    <= sq_b_q ^ tog_b;
			cnt_a_q   <= tog_a ? '0 : cnt_a_inc;
			cnt_b_q   <= tog_b ? '0 : cnt_b_inc;
		end
	end

	assign sq_a = sq_a_q;
	assign sq_b = sq_b_q;

endmodule

// ----- src/sodm_div.sv -----
// Restoring serial divider, one quotient bit per clock.
// Uses sodm_pkg for the status struct.
module sodm_div #(
	parameter int unsigned DW = 27,
	parameter int unsigned VW = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DW-1:0]         dividend,
	input  logic [VW-1:0]         divisor,
	output sodm_pkg::div_stat_t   stat,
	output logic [DW-1:0]         quot
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [VW:0]   trial;
	logic          fits;
	logic [VW:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != CW'(1);
		end
	end

	// The quotient shifts in from the right as the dividend shifts out the left.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == CW'(1));
	assign quot      = quo_q;

endmodule

// ----- src/sub_octave_divider_mixer.sv -----
// Top level of the sub-octave divider mixer: configuration registers,
// sequencer, shared multiply-accumulate and output register.
// Uses sodm_pkg, sodm_xdet and sodm_div.

// Each sample beat runs through a small sequencer: the crossing detectors and
// square waves update on the accepting edge, then the accumulate steps build
// the weighted sum of the dry sample and both squares with one shared 10-bit by
// SAMPLE_BITS multiplier and adder, then a serial restoring divider produces
// one quotient bit per cycle, and the output state clamps and signs the result
// into the output register. A new sample is taken only once the sequencer is
// back in idle. in_stall is high from the accepting edge until the sequencer
// returns to idle. The output register holds a finished beat on its own, so
// the next sample can be accepted and processed while the previous result
// still waits under out_stall; the sequencer only waits at the very end if
// that result has not been taken yet. Configuration is written through cfg_we,
// cfg_index and cfg_data; indexes with no register are ignored.
module sub_octave_divider_mixer #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [sodm_pkg::MODE_W-1:0]          cfg_index,
	input  logic [sodm_pkg::CFG_W-1:0]           cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample_in,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]        mix_out
);

	// Accumulator width: three gains of up to 511 times full scale.
	localparam int unsigned NW = SAMPLE_BITS + 11;
	localparam int unsigned PW = SAMPLE_BITS + 10;
	localparam int unsigned TW = SAMPLE_BITS + 8;
	localparam logic [SAMPLE_BITS-1:0] FS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [NW-1:0] FS_Q = NW'(FS);
	localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Configuration registers.
	logic [sodm_pkg::GAIN_W-1:0]         dry_gain_q;
	logic signed [sodm_pkg::LEVEL_W-1:0] xover_q;
	logic [sodm_pkg::GAIN_W-1:0]         sub1_gain_q;
	logic [sodm_pkg::GAIN_W-1:0]         sub2_gain_q;
	logic [sodm_pkg::MODE_W-1:0]         div_mode_q;

	sodm_pkg::seq_state_t state_q;
	sodm_pkg::seq_state_t state_d;
	logic [1:0]                         step_q;
	logic                               in_accept;
	logic                               div_start;
	logic                               out_load;

	logic signed [SAMPLE_BITS-1:0]      sample_q;
	logic signed [NW-1:0]               acc_q;
	logic                               neg_q;
	logic [sodm_pkg::DEN_W-1:0]         den_q;
	logic                               out_valid_q;
	logic signed [SAMPLE_BITS-1:0]      mix_q;

	logic                               sq_a;
	logic                               sq_b;
	logic signed [PW-1:0]               prod;
	logic [sodm_pkg::GAIN_W-1:0]        term_gain;
	logic                               term_pos;
	logic [TW-1:0]                      term_mag;
	logic signed [NW-1:0]               term;
	logic [NW-1:0]                      acc_mag;
	logic [NW-1:0]                      dividend;
	logic [NW-1:0]                      quot;
	logic [NW-1:0]                      quot_c;
	logic [SAMPLE_BITS-1:0]             res_mag;
	sodm_pkg::div_stat_t                div_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_gain_q  <= '0;
			xover_q     <= '0;
			sub1_gain_q <= sodm_pkg::Q8_ONE;
			sub2_gain_q <= '0;
			div_mode_q  <= '0;
		end else if (cfg_we) begin
			unique case (sodm_pkg::cfg_reg_t'(cfg_index))
				sodm_pkg::REG_DRY_GAIN:  dry_gain_q  <= cfg_data[sodm_pkg::GAIN_W-1:0];
				sodm_pkg::REG_XOVER_LVL: xover_q     <= cfg_data[sodm_pkg::LEVEL_W-1:0];
				sodm_pkg::REG_SUB1_GAIN: sub1_gain_q <= cfg_data[sodm_pkg::GAIN_W-1:0];
				sodm_pkg::REG_SUB2_GAIN: sub2_gain_q <= cfg_data[sodm_pkg::GAIN_W-1:0];
				sodm_pkg::REG_DIV_MODE:  div_mode_q  <= cfg_data[sodm_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = state_q != sodm_pkg::ST_IDLE;

	sodm_xdet #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_xdet (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_accept),
		.sample (sample_in),
		.level  (xover_q),
		.mode   (div_mode_q),
		.sq_a   (sq_a),
		.sq_b   (sq_b)
	);

	// Shared accumulate datapath. A square at full scale weighted by a gain is
	// the gain shifted up minus the gain itself, so no second multiplier.
	always_comb begin
		prod      = $signed({1'b0, dry_gain_q}) * sample_q;
		term_gain = (step_q == 2'd1) ? sub1_gain_q : sub2_gain_q;
		term_pos  = (step_q == 2'd1) ? sq_a : sq_b;
		term_mag  = {term_gain, {(SAMPLE_BITS-1){1'b0}}} - TW'(term_gain);
		term      = term_pos ? $signed(NW'(term_mag)) : -$signed(NW'(term_mag));
		acc_mag   = acc_q[NW-1] ? NW'(-acc_q) : NW'(acc_q);
		dividend  = {acc_mag[NW-2:0], 1'b0};
		quot_c    = (quot > FS_Q) ? FS_Q : quot;
		res_mag   = quot_c[SAMPLE_BITS-1:0];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sodm_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == sodm_pkg::ST_MAC) ? step_q + 2'd1 : 2'd0;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			sodm_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = sodm_pkg::ST_MAC;
				end
			end
			sodm_pkg::ST_MAC: begin
				if (step_q == 2'd3) begin
					div_start = 1'b1;
					state_d   = sodm_pkg::ST_DIV;
				end
			end
			sodm_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = sodm_pkg::ST_OUT;
				end
			end
			sodm_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = sodm_pkg::ST_IDLE;
				end
			end
			default: state_d = sodm_pkg::ST_IDLE;
		endcase
	end

	// Datapath registers: the product on the first step, each square term on
	// the next two, then the sign and divisor are captured as the divider starts.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= sample_in;
		end
		if (state_q == sodm_pkg::ST_MAC) begin
			unique case (step_q)
				2'd0: acc_q <= NW'(prod);
				2'd1: acc_q <= acc_q + term;
				2'd2: acc_q <= acc_q + term;
				2'd3: begin
					neg_q <= acc_q[NW-1];
					den_q <= sodm_pkg::DEN_W'(dry_gain_q) + sodm_pkg::DEN_W'(sub1_gain_q)
					       + sodm_pkg::DEN_W'(sub2_gain_q) + sodm_pkg::DEN_W'(sodm_pkg::Q8_ONE);
				end
				default: ;
			endcase
		end
	end

	// The divider sees the divisor only from its first iteration on, after
	// den_q has settled on the starting edge.
	sodm_div #(
		.DW(NW),
		.VW(sodm_pkg::DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (den_q),
		.stat     (div_stat),
		.quot     (quot)
	);

	// Output register, parting the sequencer from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mix_q <= neg_q ? -$signed(res_mag) : $signed(res_mag);
		end
	end

	assign out_valid = out_valid_q;
	assign mix_out   = mix_q;

	// The divider only finishes while the sequencer waits on it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == sodm_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	// A new sample never arrives while the divider still works on the last one.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |-> !div_stat.busy)
		else $error("sample accepted while divider busy");

	// The clamp keeps the most negative code out of every result.
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> mix_q != MOST_NEG)
		else $error("result outside the clamp range");

endmodule

// ----- tb/sv/sub_octave_divider_mixer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sub-octave divider mixer: drives sample beats and
// configuration writes, predicts every mix and checks it beat by beat.
// Depends on sodm_pkg and sub_octave_divider_mixer.
module sub_octave_divider_mixer_tb;

	localparam int SW = 16;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 5;
	// A pause after the last result comes back; it lets the block settle fully.
	localparam int SETTLE_CYCLES = SW + 20;
	localparam int HOLD_CYCLES = 600;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 106;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam longint FULL_SCALE = (longint'(1) << (SW - 1)) - 1;
	localparam logic signed [SW-1:0] MOST_POS = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] MOST_NEG = {1'b1, {(SW - 1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sodm_pkg::MODE_W-1:0] cfg_index = sodm_pkg::REG_DRY_GAIN;
	logic [sodm_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SW-1:0] mix_out;

	sub_octave_divider_mixer #(
		.SAMPLE_BITS(SW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mix_out(mix_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Our copy of the configuration registers, starting from their reset values.
	logic [sodm_pkg::GAIN_W-1:0] cur_dry = '0;
	logic signed [sodm_pkg::LEVEL_W-1:0] cur_level = '0;
	logic [sodm_pkg::GAIN_W-1:0] cur_sub1 = sodm_pkg::Q8_ONE;
	logic [sodm_pkg::GAIN_W-1:0] cur_sub2 = '0;
	logic [sodm_pkg::MODE_W-1:0] cur_mode = '0;

	// Our copy of the two crossing detectors and their square waves. Detector A
	// drives the divide-by-K square, detector B the divide-by-2K square.
	bit a_high = 1'b0;
	bit a_level = 1'b0;
	logic [sodm_pkg::CNT_W-1:0] a_count = '0;
	bit b_high = 1'b0;
	bit b_level = 1'b0;
	logic [sodm_pkg::CNT_W-1:0] b_count = '0;

	// Samples waiting to be offered, and mixes waiting to come out.
	logic signed [SW-1:0] sample_queue[$];
	logic signed [SW-1:0] mix_queue[$];

	int items_queued = 0;
	int items_taken = 0;
	int results_done = 0;
	int err_count = 0;
	int cycle_count = 0;

	// Handshake bookkeeping: the falling-edge processes need to know whether the
	// previous rising edge moved a beat on each channel.
	bit in_took = 1'b0;
	bit out_took = 1'b0;
	bit idle_on = 1'b1;
	int send_wait = 0;
	int rx_wait = 0;
	bit hold_armed = 1'b0;
	bit hold_used = 1'b0;
	int hold_left = 0;
	logic signed [SW-1:0] want_mix;

	// Advances both detectors by one sample and returns the mix the block must
	// produce for it. The squares updated by this sample already count in its mix.
	function automatic logic signed [SW-1:0] next_mix(input logic signed [SW-1:0] smp);
		int k;
		bit now_high;
		longint wave_a, wave_b, num, den, quo;
		// Divide modes above the maximum behave like the maximum.
		k = int'((cur_mode > sodm_pkg::MODE_MAX) ? sodm_pkg::MODE_MAX : cur_mode)
			+ int'(sodm_pkg::K_BASE);
		now_high = (smp > cur_level);
		if (now_high != a_high) begin
			a_high = now_high;
			a_count = a_count + 1'b1;
		end
		if (int'(a_count) >= k) begin
			a_level = !a_level;
			a_count = '0;
		end
		if (now_high != b_high) begin
			b_high = now_high;
			b_count = b_count + 1'b1;
		end
		if (int'(b_count) >= 2 * k) begin
			b_level = !b_level;
			b_count = '0;
		end
		wave_a = a_level ? FULL_SCALE : -FULL_SCALE;
		wave_b = b_level ? FULL_SCALE : -FULL_SCALE;
		num = longint'(cur_dry) * longint'(smp) + longint'(cur_sub1) * wave_a
			+ longint'(cur_sub2) * wave_b;
		den = longint'(cur_dry) + longint'(cur_sub1) + longint'(cur_sub2)
			+ longint'(sodm_pkg::Q8_ONE);
		// Integer division truncates toward zero, as the block's divider does.
		quo = (2 * num) / den;
		if (quo > FULL_SCALE) quo = FULL_SCALE;
		if (quo < -FULL_SCALE) quo = -FULL_SCALE;
		return quo[SW-1:0];
	endfunction

	// Sender: holds a beat until it is taken, then, while idling is on, waits a
	// random number of cycles before offering the next one. Valid is only ever
	// changed once per falling edge, so back-to-back beats keep it high.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_took)) begin
			if (in_valid) send_wait = idle_on ? $urandom_range(0, 5) : 0;
			if (send_wait == 0 && sample_queue.size() > 0) begin
				sample_in <= sample_queue.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (send_wait > 0) send_wait = send_wait - 1;
			end
		end
	end

	// Long receiver hold-off, counted here on its own. It starts once when the
	// stimulus arms it and keeps the output stalled while the sender keeps
	// offering, so the block fills up and stalls its input.
	always @(negedge clk) begin
		if (hold_armed && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver: after each taken result it stalls for a random number of cycles while idling is on.
	always @(negedge clk) begin
		if (out_took) begin
			rx_wait = idle_on ? $urandom_range(0, 5) : 0;
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
		end
		out_stall <= (rx_wait > 0) || (hold_left > 0);
	end

	// Monitor: predicts a mix for every accepted sample and checks every
	// accepted result against the oldest prediction.
	always @(posedge clk) begin
		in_took <= in_valid && !in_stall;
		out_took <= out_valid && !out_stall;
		if (arst_n && in_valid && !in_stall) begin
			mix_queue.push_back(next_mix(sample_in));
			items_taken <= items_taken + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			results_done <= results_done + 1;
			if (mix_queue.size() == 0) begin
				err_count = err_count + 1;
				if (err_count <= MAX_REPORTS)
					$display("%0t: mix_out %0d arrived with no sample pending", $realtime,
						mix_out);
			end else begin
				want_mix = mix_queue.pop_front();
				if (mix_out !== want_mix) begin
					err_count = err_count + 1;
					if (err_count <= MAX_REPORTS)
						$display("%0t: mix_out mismatch, expected %0d, got %0d", $realtime,
							want_mix, mix_out);
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_sample(input logic signed [SW-1:0] smp);
		sample_queue.push_back(smp);
		items_queued = items_queued + 1;
	endtask

	// Waits until every queued sample was taken and every mix came back, then
	// lets the block settle before anything else touches its registers.
	task automatic wait_drained();
		do @(negedge clk);
		while (items_taken != items_queued || results_done != items_taken);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input sodm_pkg::cfg_reg_t idx,
		input logic [sodm_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			sodm_pkg::REG_DRY_GAIN: cur_dry = val[sodm_pkg::GAIN_W-1:0];
			sodm_pkg::REG_XOVER_LVL: cur_level = val[sodm_pkg::LEVEL_W-1:0];
			sodm_pkg::REG_SUB1_GAIN: cur_sub1 = val[sodm_pkg::GAIN_W-1:0];
			sodm_pkg::REG_SUB2_GAIN: cur_sub2 = val[sodm_pkg::GAIN_W-1:0];
			sodm_pkg::REG_DIV_MODE: cur_mode = val[sodm_pkg::MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [sodm_pkg::GAIN_W-1:0] dry,
		input logic [sodm_pkg::LEVEL_W-1:0] lvl,
		input logic [sodm_pkg::GAIN_W-1:0] sub1, input logic [sodm_pkg::GAIN_W-1:0] sub2,
		input logic [sodm_pkg::MODE_W-1:0] mode);
		write_reg(sodm_pkg::REG_DRY_GAIN, sodm_pkg::CFG_W'(dry));
		write_reg(sodm_pkg::REG_XOVER_LVL, sodm_pkg::CFG_W'(lvl));
		write_reg(sodm_pkg::REG_SUB1_GAIN, sodm_pkg::CFG_W'(sub1));
		write_reg(sodm_pkg::REG_SUB2_GAIN, sodm_pkg::CFG_W'(sub2));
		write_reg(sodm_pkg::REG_DIV_MODE, sodm_pkg::CFG_W'(mode));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Gains are drawn with weight on zero, unity and the largest 9-bit value.
	function automatic logic [sodm_pkg::GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return sodm_pkg::Q8_ONE;
			2: return '1;
			default: return sodm_pkg::GAIN_W'($urandom_range(0, (1 << sodm_pkg::GAIN_W) - 1));
		endcase
	endfunction

	initial begin
		int pick;
		int run_left;
		bit go_up;
		longint v;
		run_left = 0;
		go_up = 1'b0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, first with the reset configuration untouched: full-scale
		// swings across a zero threshold, the most negative sample and small
		// values on both sides of zero.
		@(posedge clk);
		queue_sample(16'sd0);
		queue_sample(MOST_POS);
		queue_sample(MOST_NEG);
		queue_sample(16'sd1);
		queue_sample(-16'sd1);
		queue_sample(MOST_POS);
		queue_sample(MOST_NEG);
		queue_sample(16'sd100);
		queue_sample(-16'sd100);
		wait_drained();

		// Gains above unity, a threshold at the bottom of the 16-bit range and a
		// divide mode past the maximum. Only the most negative sample is not above.
		set_config('1, MOST_NEG, '1, '1, 3'd7);
		@(posedge clk);
		queue_sample(MOST_NEG);
		queue_sample(-16'sd32767);
		queue_sample(MOST_POS);
		queue_sample(MOST_NEG);
		queue_sample(16'sd0);
		queue_sample(MOST_NEG);
		queue_sample(16'sd5);
		queue_sample(MOST_NEG);
		wait_drained();

		// All gains zero, so the mix must be zero; threshold at the top of the range
		// and the other out-of-range divide mode.
		set_config('0, MOST_POS, '0, '0, 3'd6);
		@(posedge clk);
		queue_sample(MOST_POS);
		queue_sample(MOST_NEG);
		queue_sample(16'sd0);
		queue_sample(16'sd12345);
		wait_drained();

		// Random part. The first two phases pin the extremes of the stated ranges;
		// the rest draw their settings. Most samples swing back and forth across the
		// threshold in short runs so the dividers keep toggling; the rest are noise
		// and edge values.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0)
				set_config('0, -16'sd32761, sodm_pkg::Q8_ONE, sodm_pkg::Q8_ONE, '0);
			else if (phase == 1)
				set_config(sodm_pkg::Q8_ONE, 16'sd32761, '0, sodm_pkg::Q8_ONE,
					sodm_pkg::MODE_MAX);
			else
				set_config(pick_gain(),
					($urandom_range(0, 3) == 0) ? sodm_pkg::LEVEL_W'($urandom)
						: sodm_pkg::LEVEL_W'(int'($urandom_range(0, 65522)) - 32761),
					pick_gain(), pick_gain(), sodm_pkg::MODE_W'($urandom_range(0, 7)));
			@(posedge clk);
			// One phase runs with no idling on either side at all.
			idle_on = (phase != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					if (run_left == 0) begin
						go_up = !go_up;
						run_left = $urandom_range(1, 4);
					end
					run_left = run_left - 1;
					v = longint'(cur_level) + (go_up ? longint'($urandom_range(1, 3000))
						: -longint'($urandom_range(0, 3000)));
					if (v > longint'(MOST_POS)) v = longint'(MOST_POS);
					if (v < longint'(MOST_NEG)) v = longint'(MOST_NEG);
					queue_sample(v[SW-1:0]);
				end else if (pick < 8) begin
					queue_sample(SW'($urandom));
				end else begin
					case ($urandom_range(0, 3))
						0: queue_sample(MOST_NEG);
						1: queue_sample(MOST_POS);
						2: queue_sample(cur_level);
						default: queue_sample(cur_level + 1'b1);
					endcase
				end
			end
			// Midway through the run the receiver goes quiet for a long stretch
			// while this phase's samples are still being offered.
			if (phase == 3) hold_armed = 1'b1;
			wait_drained();
		end

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
